// ----- rtl/core/bf3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types and constants for the 3x3 RGB box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int MAX_SIDE     = 512;
  localparam int CHANNEL_BITS = 16;
  localparam int SIDE_BITS    = $clog2(MAX_SIDE + 1);
  localparam int POS_BITS     = $clog2(MAX_SIDE);
  localparam int SUM_BITS     = CHANNEL_BITS + 4;
  localparam int RECIP_SHIFT  = SUM_BITS;
  localparam int RECIP_BITS   = SUM_BITS - 1;
  // floor(2^RECIP_SHIFT / d), the quotient is fixed up by one step afterwards
  localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 3);
  localparam logic [RECIP_BITS-1:0] RECIP_9 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 9);

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [2:0][CHANNEL_BITS-1:0] pix_t;
  typedef logic [SUM_BITS-1:0] sum_t;

  // divisor selection for the clipped neighbor count
  typedef enum logic [2:0] {
    DIV1, DIV2, DIV3, DIV4, DIV6, DIV9
  } div_t;

  // counts are 1..3 rows times 1..3 columns
  function automatic div_t div_code(input logic [1:0] nrow, input logic [1:0] ncol);
    div_t d;
    d = DIV1;
    case ({nrow, ncol})
      4'b0101: d = DIV1;
      4'b0110, 4'b1001: d = DIV2;
      4'b0111, 4'b1101: d = DIV3;
      4'b1010: d = DIV4;
      4'b1011, 4'b1110: d = DIV6;
      4'b1111: d = DIV9;
      default: d = DIV1;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/core/box_filter_3x3_rgb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb
// Streaming 3x3 mean filter over a square RGB image, two line memories.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock when not stalled. Each pixel gives
// 0 to 4 result beats (the neighborhood mean of earlier pixels, tagged with row
// and column); a pixel that gives more than one result holds off input until
// all its results are issued, since the result sequencer issues one beat per
// cycle while the output is not stalled. An ordinary pixel gives one result;
// a row end gives two, the final row two and its last pixel four. The line
// memories need no clearing, so the block is ready right after reset. Writing
// image_side restarts the image at row 0, column 0.
module box_filter_3x3_rgb (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bf3_pkg::SIDE_BITS-1:0]     image_side,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bf3_pkg::CHANNEL_BITS-1:0]  red_in,
  input  logic [bf3_pkg::CHANNEL_BITS-1:0]  green_in,
  input  logic [bf3_pkg::CHANNEL_BITS-1:0]  blue_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bf3_pkg::CHANNEL_BITS-1:0]  red_out,
  output logic [bf3_pkg::CHANNEL_BITS-1:0]  green_out,
  output logic [bf3_pkg::CHANNEL_BITS-1:0]  blue_out,
  output logic [bf3_pkg::POS_BITS-1:0]      out_row,
  output logic [bf3_pkg::POS_BITS-1:0]      out_col,
  output logic                              run_last
);
  import bf3_pkg::*;

  // configuration and position counters
  logic [SIDE_BITS-1:0] side;
  logic [POS_BITS-1:0]  row_cnt, col_cnt;

  // line memories
  pix_t older_mem [MAX_SIDE];
  pix_t newer_mem [MAX_SIDE];

  // stage 1: pixel waiting for line data
  logic                 v1, fwd1;
  pix_t                 pix1, older_rd, newer_rd, fwd_old, fwd_new;
  logic [POS_BITS-1:0]  addr1, row1, col1;
  logic [1:0]           rlo1, clo1;
  logic                 rprev1, rcur1, cprev1, ccur1;
  pix_t                 older_eff, newer_eff;

  // stage 2: window and result sequencer
  pix_t                 win [3][3];
  logic                 v2;
  logic [POS_BITS-1:0]  row2, col2;
  logic [1:0]           rlo2, clo2, idx;
  logic                 rprev2, rcur2, cprev2, ccur2;

  // stage 3: sums, stage 4: quotient estimate
  logic                 v3, v4;
  sum_t                 sum3 [3];
  div_t                 code3, code4;
  logic [POS_BITS-1:0]  orow3, ocol3, orow4, ocol4;
  logic                 last3, last4;
  sum_t                 xs4 [3], q4 [3];

  logic en1, en2, en3, en4, ld5, accept, adv1, done2, emit2;
  logic [2:0] nres;
  logic       a_cur, b_cur, last2;
  logic [2:0] rmask, cmask;
  logic [1:0] nrow, ncol;
  sum_t       sum2 [3];
  logic [SIDE_BITS-1:0] col_inc, row_inc;

  assign cfg_ready = 1'b1;

  // pipeline flow
  assign ld5    = !out_valid || !out_stall;
  assign en4    = !v4 || ld5;
  assign en3    = !v3 || en4;
  assign nres   = 3'(({1'b0, rprev2} + {1'b0, rcur2}) * ({1'b0, cprev2} + {1'b0, ccur2}));
  assign done2  = (nres == 3'd0) || ({1'b0, idx} == nres - 3'd1);
  assign emit2  = v2 && (nres != 3'd0) && en3;
  assign en2    = !v2 || (done2 && ((nres == 3'd0) || en3));
  assign en1    = !v1 || en2;
  assign adv1   = v1 && en2;
  assign in_stall = !en1;
  assign accept = in_valid && en1;

  // position counters
  assign col_inc = {1'b0, col_cnt} + SIDE_BITS'(1);
  assign row_inc = {1'b0, row_cnt} + SIDE_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      side    <= SIDE_BITS'(MAX_SIDE);
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (cfg_valid) begin
      if (image_side == '0) side <= SIDE_BITS'(1);
      else if (image_side > SIDE_BITS'(MAX_SIDE)) side <= SIDE_BITS'(MAX_SIDE);
      else side <= image_side;
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      if (col_inc >= side) begin
        col_cnt <= '0;
        row_cnt <= (row_inc >= side) ? '0 : row_inc[POS_BITS-1:0];
      end else begin
        col_cnt <= col_inc[POS_BITS-1:0];
      end
    end
  end

  // line memory read on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      older_rd <= older_mem[col_cnt];
      newer_rd <= newer_mem[col_cnt];
    end
  end

  // line memory write back as the pixel leaves stage 1
  always_ff @(posedge clk) begin
    if (adv1) begin
      older_mem[addr1] <= newer_eff;
      newer_mem[addr1] <= pix1;
    end
  end

  assign older_eff = fwd1 ? fwd_old : older_rd;
  assign newer_eff = fwd1 ? fwd_new : newer_rd;

  // stage 1 registers, forward when the same entry is written and read
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      fwd1 <= 1'b0;
    end else if (en1) begin
      v1   <= accept;
      fwd1 <= accept && adv1 && (addr1 == col_cnt);
    end
    if (accept) begin
      pix1    <= {blue_in, green_in, red_in};
      addr1   <= col_cnt;
      row1    <= row_cnt;
      col1    <= col_cnt;
      rlo1    <= (row_cnt >= POS_BITS'(2)) ? 2'd2 : row_cnt[1:0];
      clo1    <= (col_cnt >= POS_BITS'(2)) ? 2'd2 : col_cnt[1:0];
      rprev1  <= row_cnt != '0;
      rcur1   <= row_inc == side;
      cprev1  <= col_cnt != '0;
      ccur1   <= col_inc == side;
      fwd_old <= newer_eff;
      fwd_new <= pix1;
    end
  end

  // window shift and stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      v2  <= 1'b0;
      idx <= '0;
    end else if (en2) begin
      v2  <= v1;
      idx <= '0;
    end else if (emit2) begin
      idx <= idx + 2'd1;
    end
    if (adv1) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= older_eff;
      win[1][2] <= newer_eff;
      win[2][2] <= pix1;
      row2   <= row1;
      col2   <= col1;
      rlo2   <= rlo1;
      clo2   <= clo1;
      rprev2 <= rprev1;
      rcur2  <= rcur1;
      cprev2 <= cprev1;
      ccur2  <= ccur1;
    end
  end

  // pick the row and column of this result and clip the window
  always_comb begin
    if (cprev2 && ccur2) begin
      b_cur = idx[0];
      a_cur = (rprev2 && rcur2) ? idx[1] : rcur2;
    end else begin
      b_cur = ccur2;
      a_cur = (rprev2 && rcur2) ? idx[0] : rcur2;
    end
    rmask = {1'b1, rlo2 != 2'd0, (rlo2 == 2'd2) && !a_cur};
    cmask = {1'b1, clo2 != 2'd0, (clo2 == 2'd2) && !b_cur};
    nrow  = 2'd1 + {1'b0, rmask[1]} + {1'b0, rmask[0]};
    ncol  = 2'd1 + {1'b0, cmask[1]} + {1'b0, cmask[0]};
    last2 = done2;
    for (int k = 0; k < 3; k++) begin
      sum2[k] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (rmask[i] && cmask[j]) sum2[k] = sum2[k] + SUM_BITS'(win[i][j][k]);
        end
      end
    end
  end

  // stage 3: sums and divisor
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en3) v3 <= v2 && (nres != 3'd0);
    if (emit2) begin
      sum3  <= sum2;
      code3 <= div_code(nrow, ncol);
      orow3 <= a_cur ? row2 : row2 - POS_BITS'(1);
      ocol3 <= b_cur ? col2 : col2 - POS_BITS'(1);
      last3 <= last2;
    end
  end

  // stage 4: reciprocal multiply
  always_ff @(posedge clk) begin
    logic [SUM_BITS+RECIP_BITS-1:0] prod;
    sum_t xs;
    if (rst) v4 <= 1'b0;
    else if (en4) v4 <= v3;
    if (en4 && v3) begin
      for (int k = 0; k < 3; k++) begin
        xs   = (code3 == DIV6) ? (sum3[k] >> 1) : sum3[k];
        prod = (SUM_BITS + RECIP_BITS)'(xs) *
               (SUM_BITS + RECIP_BITS)'((code3 == DIV9) ? RECIP_9 : RECIP_3);
        xs4[k] <= xs;
        q4[k]  <= SUM_BITS'(prod[RECIP_SHIFT +: RECIP_BITS]);
      end
      code4 <= code3;
      orow4 <= orow3;
      ocol4 <= ocol3;
      last4 <= last3;
    end
  end

  // output register with one-step quotient fix
  always_ff @(posedge clk) begin
    sum_t qd, rem, qf;
    chan_t res [3];
    if (rst) out_valid <= 1'b0;
    else if (ld5) out_valid <= v4;
    if (ld5 && v4) begin
      for (int k = 0; k < 3; k++) begin
        qd  = (code4 == DIV9) ? q4[k] + (q4[k] << 3) : q4[k] + (q4[k] << 1);
        rem = xs4[k] - qd;
        qf  = (rem >= ((code4 == DIV9) ? SUM_BITS'(9) : SUM_BITS'(3))) ? q4[k] + SUM_BITS'(1)
                                                                        : q4[k];
        case (code4)
          DIV1:    res[k] = xs4[k][CHANNEL_BITS-1:0];
          DIV2:    res[k] = xs4[k][CHANNEL_BITS:1];
          DIV4:    res[k] = xs4[k][CHANNEL_BITS+1:2];
          default: res[k] = qf[CHANNEL_BITS-1:0];
        endcase
      end
      red_out   <= res[0];
      green_out <= res[1];
      blue_out  <= res[2];
      out_row   <= orow4;
      out_col   <= ocol4;
      run_last  <= last4;
    end
  end

`ifndef ASSERT_OFF
  a_idx_needs_item: assert property (@(posedge clk) disable iff (rst)
    (idx != 2'd0) |-> v2) else $error("result index set without an item");
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    fwd1 |-> v1) else $error("forward flag without an item");
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> ({1'b0, idx} < nres || nres == 3'd0)) else $error("result index out of range");
  a_col_in_image: assert property (@(posedge clk) disable iff (rst)
    v3 |-> ({1'b0, ocol3} < side)) else $error("result column outside image");
`endif

endmodule
